/* rtl/core/contiguous_first_fit_allocator_macros.svh */
// Assertion macros for the allocator.
`ifndef CONTIGUOUS_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_FIRST_FIT_ALLOCATOR_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CFFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked on every clock edge outside reset.
`define CFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/cffa_pkg.sv */
// ----------------------------------------------------------------------------
// cffa_pkg
// Shared constants and types for the contiguous first-fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package cffa_pkg;
    localparam int STORE_BLOCKS = 1024;
    localparam int FILE_SLOTS   = 16;
    localparam int WORD_W       = 32;
    localparam int WORDS        = STORE_BLOCKS / WORD_W;
    localparam int WADDR_W      = $clog2(WORDS);
    localparam int BIT_W        = $clog2(WORD_W);
    localparam int BLK_W        = $clog2(STORE_BLOCKS);
    localparam int CNT_W        = BLK_W + 1;
    localparam int SLOT_W       = $clog2(FILE_SLOTS);

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_SPACE   = 3'd1;
    localparam logic [2:0] ST_NO_RUN     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_SLOT_USED  = 3'd4;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd5;

    localparam logic ACT_CREATE = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_SRD, S_SCAN, S_MARK_RD, S_MARK_WR, S_RESP
    } state_t;
endpackage
`default_nettype wire

/* rtl/core/contiguous_first_fit_allocator.sv */
// A delete reads and rewrites each map word it touches; a create scans map words until
// a fit or the end of the map, then reads and rewrites each word it marks, then responds.
// The block handles one request at a time and takes a new one only when idle.
// After reset the map is cleared word by word before requests are taken.
// Reset clears control state and the slot valid bits and sets the free count to STORE_BLOCKS.
// ----------------------------------------------------------------------------
// contiguous_first_fit_allocator
// First-fit contiguous block allocator over a word-organised occupancy RAM.
// ----------------------------------------------------------------------------
`default_nettype none
`include "contiguous_first_fit_allocator_macros.svh"
module contiguous_first_fit_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // action[0], file_slot[4:1], length[15:5]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // status[2:0], start_block[12:3], free_blocks[23:13]
);
    localparam int WA = cffa_pkg::WADDR_W;
    localparam int BW = cffa_pkg::BLK_W;
    localparam int CW = cffa_pkg::CNT_W;
    localparam int SW = cffa_pkg::SLOT_W;
    localparam int WW = cffa_pkg::WORD_W;
    localparam int BI = cffa_pkg::BIT_W;

    cffa_pkg::state_t state_reg, state_next;
    logic          clr_reg, clr_next;
    logic [WA-1:0] clr_addr_reg, clr_addr_next;
    logic          act_reg, act_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] free_reg, free_next;
    logic [cffa_pkg::FILE_SLOTS-1:0] valid_reg, valid_next;
    logic [BW-1:0] est_reg [cffa_pkg::FILE_SLOTS];
    logic [CW-1:0] elen_reg [cffa_pkg::FILE_SLOTS];
    logic [WA-1:0] waddr_reg, waddr_next;
    logic [BW:0]   blk_reg, blk_next;
    logic [CW-1:0] run_reg, run_next;
    logic [BW-1:0] start_reg, start_next;
    logic [CW-1:0] left_reg, left_next;
    logic [2:0]    status_reg, status_next;
    logic          ovalid_reg, ovalid_next;
    logic [23:0]   odata_reg, odata_next;
    logic          wr_slot;

    logic          ram_we;
    logic [WA-1:0] ram_waddr, ram_raddr;
    logic [WW-1:0] ram_wdata, ram_rdata;

    cffa_ram #(.WIDTH(WW), .DEPTH(cffa_pkg::WORDS)) u_map (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    logic [WW-1:0] scan_word;
    logic [WW-1:0] mark_mask;
    logic [CW-1:0] run_c [WW];
    logic [WW-1:0] hit_v;
    logic          hit_any;
    logic [BI-1:0] hit_idx;
    logic [BW:0]   hit_blk;
    logic [BW-1:0] word_base;

    assign word_base = {waddr_reg, {cffa_pkg::BIT_W{1'b0}}};

    // free-run length ending at each bit of the map word, resolved per bit
    always_comb
    begin
        logic [BI:0] last1;
        scan_word = ram_rdata;
        for (int i = 0; i < WW; i++)
        begin
            last1 = '0;
            for (int j = 0; j <= i; j++)
            begin
                if (ram_rdata[j])
                begin
                    last1 = (BI+1)'(j + 1);
                end
            end
            if (last1 == '0)
                run_c[i] = run_reg + CW'(i + 1);
            else
                run_c[i] = CW'(i + 1) - CW'(last1);
            hit_v[i] = !ram_rdata[i] && (run_c[i] == len_reg);
        end
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = WW - 1; i >= 0; i--)
        begin
            if (hit_v[i])
            begin
                hit_any = 1'b1;
                hit_idx = BI'(i);
            end
        end
    end

    assign hit_blk = {1'b0, waddr_reg, hit_idx};

    // bits of this word covered by [blk_reg, blk_reg+left_reg)
    always_comb
    begin
        for (int i = 0; i < WW; i++)
        begin
            mark_mask[i] = ((BW+1)'(word_base) + (BW+1)'(i) >= blk_reg) &&
                           ({1'b0, (BW+1)'(word_base) + (BW+1)'(i)} <
                            {1'b0, blk_reg} + (BW+2)'(left_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cffa_pkg::S_IDLE;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            free_reg     <= CW'(cffa_pkg::STORE_BLOCKS);
            valid_reg    <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
            free_reg     <= free_next;
            valid_reg    <= valid_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        slot_reg   <= slot_next;
        len_reg    <= len_next;
        waddr_reg  <= waddr_next;
        blk_reg    <= blk_next;
        run_reg    <= run_next;
        start_reg  <= start_next;
        left_reg   <= left_next;
        status_reg <= status_next;
        odata_reg  <= odata_next;
        if (wr_slot)
        begin
            est_reg[slot_reg]  <= start_reg;
            elen_reg[slot_reg] <= len_reg;
        end
    end

    always_comb
    begin
        logic [SW-1:0] in_slot;
        logic [CW-1:0] in_len;
        logic [BW:0]   nb;
        logic [CW:0]   fsum;
        in_slot = s_tdata[SW:1];
        in_len  = s_tdata[15:5];
        state_next    = state_reg;
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        act_next      = act_reg;
        slot_next     = slot_reg;
        len_next      = len_reg;
        free_next     = free_reg;
        valid_next    = valid_reg;
        waddr_next    = waddr_reg;
        blk_next      = blk_reg;
        run_next      = run_reg;
        start_next    = start_reg;
        left_next     = left_reg;
        status_next   = status_reg;
        odata_next    = odata_reg;
        ovalid_next   = ovalid_reg && !m_tready;
        wr_slot       = 1'b0;
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = waddr_reg;
        ram_wdata     = scan_word & ~mark_mask;
        ram_raddr     = waddr_reg;
        nb            = '0;
        fsum          = '0;
        unique case (state_reg)
            cffa_pkg::S_IDLE:
            begin
                if (clr_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = clr_addr_reg;
                    ram_wdata = '0;
                    clr_addr_next = clr_addr_reg + WA'(1);
                    if (clr_addr_reg == WA'(cffa_pkg::WORDS - 1))
                    begin
                        clr_next = 1'b0;
                    end
                end
                else
                begin
                    s_tready = 1'b1;
                    if (s_tvalid)
                    begin
                        act_next   = s_tdata[0];
                        slot_next  = in_slot;
                        len_next   = in_len;
                        status_next = cffa_pkg::ST_OK;
                        start_next = '0;
                        run_next   = '0;
                        waddr_next = '0;
                        state_next = cffa_pkg::S_RESP;
                        if (s_tdata[0] == cffa_pkg::ACT_CREATE)
                        begin
                            if (valid_reg[in_slot])
                                status_next = cffa_pkg::ST_SLOT_USED;
                            else if (in_len == '0)
                                status_next = cffa_pkg::ST_BAD_LENGTH;
                            else if (in_len > free_reg)
                                status_next = cffa_pkg::ST_NO_SPACE;
                            else
                                state_next = cffa_pkg::S_SRD;
                        end
                        else
                        begin
                            if (!valid_reg[in_slot])
                                status_next = cffa_pkg::ST_NOT_FOUND;
                            else
                            begin
                                start_next = est_reg[in_slot];
                                blk_next   = {1'b0, est_reg[in_slot]};
                                left_next  = elen_reg[in_slot];
                                len_next   = elen_reg[in_slot];
                                waddr_next = est_reg[in_slot][BW-1:cffa_pkg::BIT_W];
                                state_next = cffa_pkg::S_MARK_RD;
                            end
                        end
                    end
                end
            end
            cffa_pkg::S_SRD:
            begin
                state_next = cffa_pkg::S_SCAN;
            end
            cffa_pkg::S_SCAN:
            begin
                run_next = run_c[WW-1];
                if (hit_any)
                begin
                    nb         = hit_blk + (BW+1)'(1) - (BW+1)'(len_reg);
                    start_next = nb[BW-1:0];
                    blk_next   = nb;
                    left_next  = len_reg;
                    waddr_next = nb[BW-1:cffa_pkg::BIT_W];
                    state_next = cffa_pkg::S_MARK_RD;
                end
                else if (waddr_reg == WA'(cffa_pkg::WORDS - 1))
                begin
                    status_next = cffa_pkg::ST_NO_RUN;
                    state_next  = cffa_pkg::S_RESP;
                end
                else
                begin
                    waddr_next = waddr_reg + WA'(1);
                    state_next = cffa_pkg::S_SRD;
                end
            end
            cffa_pkg::S_MARK_RD:
            begin
                state_next = cffa_pkg::S_MARK_WR;
            end
            cffa_pkg::S_MARK_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = (act_reg == cffa_pkg::ACT_CREATE) ? (scan_word | mark_mask)
                                                              : (scan_word & ~mark_mask);
                nb = (BW+1)'(word_base) + (BW+1)'(WW);
                if ({1'b0, nb} >= {1'b0, blk_reg} + (BW+2)'(left_reg) ||
                    waddr_reg == WA'(cffa_pkg::WORDS - 1))
                begin
                    state_next = cffa_pkg::S_RESP;
                    if (act_reg == cffa_pkg::ACT_CREATE)
                    begin
                        free_next = free_reg - len_reg;
                        valid_next[slot_reg] = 1'b1;
                        wr_slot = 1'b1;
                    end
                    else
                    begin
                        fsum = {1'b0, free_reg} + {1'b0, len_reg};
                        free_next = (fsum > (CW+1)'(cffa_pkg::STORE_BLOCKS))
                                    ? CW'(cffa_pkg::STORE_BLOCKS) : fsum[CW-1:0];
                        valid_next[slot_reg] = 1'b0;
                    end
                end
                else
                begin
                    waddr_next = waddr_reg + WA'(1);
                    state_next = cffa_pkg::S_MARK_RD;
                end
            end
            cffa_pkg::S_RESP:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {free_reg,
                                   (status_reg == cffa_pkg::ST_OK) ? start_reg : BW'(0),
                                   status_reg};
                    state_next  = cffa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cffa_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    `CFFA_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, clr_reg, !s_tready)
    `CFFA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `CFFA_ASSERT_IMP(a_free_bound, clk, rst_n, 1'b1, free_reg <= CW'(cffa_pkg::STORE_BLOCKS))
endmodule
`default_nettype wire

/* rtl/core/cffa_ram.sv */
// ----------------------------------------------------------------------------
// cffa_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module cffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
